[hdl/ring_buffer_deque_core_assert.svh]
// ============================================================================
// ring_buffer_deque_core_assert.svh
// Assertion macros used by the deque checker.
// ============================================================================
`ifndef RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`define RING_BUFFER_DEQUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

[hdl/rbd_pkg.sv]
// ============================================================================
// rbd_pkg
// Types and constants of the ring buffer deque.
// ============================================================================
package rbd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 4;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FRONT = 3'd4,
        OP_READ_BACK  = 3'd5,
        OP_READ_AT    = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        op_t                   operation;
        logic [DATA_WIDTH-1:0] value;
        logic [POS_W-1:0]      position;
    } cmd_word_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        status_t               status;
        logic [CNT_W-1:0]      count;
    } res_word_t;

    typedef struct packed {
        logic                  wr_en;
        logic [PTR_W-1:0]      wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [PTR_W-1:0]      rd_addr;
    } mem_req_t;

endpackage

[hdl/rbd_store.sv]
// ============================================================================
// rbd_store
// Element store: one write and one registered read per cycle.
// ============================================================================
module rbd_store (
    input  logic                          clk,
    input  rbd_pkg::mem_req_t             req,
    output logic [rbd_pkg::DATA_WIDTH-1:0] rd_data
);

    logic [rbd_pkg::DATA_WIDTH-1:0] mem [rbd_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // hold read data when no read is issued
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

[hdl/ring_buffer_deque_core.sv]
// ============================================================================
// ring_buffer_deque_core
// Fixed-depth double-ended queue in a circular element store.
// ============================================================================
// Command channel (cmd_valid, cmd_stall, cmd) carries one operation word:
// push front/back, pop front/back, read front/back, read at offset, clear.
// Result channel (res_valid, res_stall, res) returns one word per command:
// read data (zero unless a read succeeds), status and the new count.
// Head pointer and count live in registers and update at accept; the
// element store is a synchronous RAM with a registered read.
// Accepted commands pass through the s1 registers, where the store read
// lands, and then the result register, whose load raises res_valid.
// Throughput: one command per cycle while the result side keeps up.
// When res_stall holds a result, one more command may enter and wait on
// its store data; after that cmd_stall rises until the result is taken.
// Reset empties the deque (count zero, head one); store contents are
// undefined, but only entries written by a push are ever read.
// Errors (full, empty, position out of range) leave the state unchanged.
// ============================================================================
module ring_buffer_deque_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  rbd_pkg::cmd_word_t  cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output rbd_pkg::res_word_t  res
);

    localparam int PW = rbd_pkg::PTR_W;
    localparam int CW = rbd_pkg::CNT_W;

    logic [PW-1:0]               head_reg, head_next;
    logic [CW-1:0]               count_reg, count_next;
    logic                        s1_valid_reg;
    logic                        s1_rd_ok_reg;
    rbd_pkg::status_t            s1_status_reg;
    logic [CW-1:0]               s1_count_reg;
    logic                        res_valid_reg;
    rbd_pkg::res_word_t          res_reg;

    logic                        accept;
    logic                        s1_adv;
    logic                        is_full;
    logic                        is_empty;
    logic                        rd_ok;
    rbd_pkg::status_t            status;
    rbd_pkg::mem_req_t           mem_req;
    logic [rbd_pkg::DATA_WIDTH-1:0] mem_q;
    logic [PW-1:0]               cnt_lo;

    assign s1_adv    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = s1_valid_reg && !s1_adv;
    assign accept    = cmd_valid && !cmd_stall;

    assign is_full  = (count_reg == CW'(rbd_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign cnt_lo   = count_reg[PW-1:0];

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        status          = rbd_pkg::ST_OK;
        rd_ok           = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = head_reg;
        mem_req.wr_data = cmd.value;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = head_reg;
        case (cmd.operation)
            rbd_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status = rbd_pkg::ST_FULL;
                end
                else
                begin
                    head_next       = head_reg - PW'(1);
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = head_reg - PW'(1);
                    count_next      = count_reg + CW'(1);
                end
            end
            rbd_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = rbd_pkg::ST_FULL;
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = head_reg + cnt_lo;
                    count_next      = count_reg + CW'(1);
                end
            end
            rbd_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next  = head_reg + PW'(1);
                    count_next = count_reg - CW'(1);
                end
            end
            rbd_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            rbd_pkg::OP_READ_FRONT:
            begin
                if (is_empty)
                begin
                    status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_ok           = 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_reg;
                end
            end
            rbd_pkg::OP_READ_BACK:
            begin
                if (is_empty)
                begin
                    status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_ok           = 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_reg + cnt_lo - PW'(1);
                end
            end
            rbd_pkg::OP_READ_AT:
            begin
                if (CW'(cmd.position) >= count_reg)
                begin
                    status = rbd_pkg::ST_RANGE;
                end
                else
                begin
                    rd_ok           = 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_reg + PW'(cmd.position);
                end
            end
            rbd_pkg::OP_CLEAR:
            begin
                head_next  = PW'(1);
                count_next = '0;
            end
            default:
            begin
                status = rbd_pkg::ST_OK;
            end
        endcase
        // drop store accesses of a command not accepted
        mem_req.wr_en = mem_req.wr_en && accept;
        mem_req.rd_en = mem_req.rd_en && accept;
    end

    rbd_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= PW'(1);
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_ok_reg  <= rd_ok;
            s1_status_reg <= status;
            s1_count_reg  <= count_next;
        end
        if (s1_adv)
        begin
            res_reg.read_data <= s1_rd_ok_reg ? mem_q : '0;
            res_reg.status    <= s1_status_reg;
            res_reg.count     <= s1_count_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[hdl/rbd_checker.sv]
// ============================================================================
// rbd_checker
// Port-level checks of the ring buffer deque, bound to the top level.
// ============================================================================
`include "ring_buffer_deque_core_assert.svh"

module rbd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_stall,
    input rbd_pkg::res_word_t res
);

    logic res_err;
    logic res_full;
    logic res_empty;
    logic count_at_depth;
    logic count_in_range;

    assign res_err        = res_valid && (res.status != rbd_pkg::ST_OK);
    assign res_full       = res_valid && (res.status == rbd_pkg::ST_FULL);
    assign res_empty      = res_valid && (res.status == rbd_pkg::ST_EMPTY);
    assign count_at_depth = (res.count == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign count_in_range = (res.count <= rbd_pkg::CNT_W'(rbd_pkg::DEPTH));

    `RBD_ASSERT_NOW(a_count_bound, res_valid, count_in_range)

    `RBD_ASSERT_NOW(a_error_zero_data, res_err, res.read_data == '0)

    `RBD_ASSERT_NOW(a_full_count, res_full, count_at_depth)

    `RBD_ASSERT_NOW(a_empty_count, res_empty, res.count == '0)

    `RBD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind ring_buffer_deque_core rbd_checker u_rbd_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for ring_buffer_deque_core. A queue of command
// words (a short directed opening, then random segments that lean toward
// filling, draining or reading, or to none) feeds a bursty driver. A shadow
// deque predicts each result word, and a monitor compares every accepted
// result field by field while the result side stalls on its own pattern.
// ============================================================================
module tb_top;

    localparam int RANDOM_WORDS = 750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DEPTH        = rbd_pkg::DEPTH;
    localparam int DW           = rbd_pkg::DATA_WIDTH;
    localparam int CW           = rbd_pkg::CNT_W;
    localparam int PSW          = rbd_pkg::POS_W;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    rbd_pkg::cmd_word_t cmd       = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    rbd_pkg::res_word_t res;

    rbd_pkg::cmd_word_t pending_cmds[$];
    rbd_pkg::res_word_t expected_results[$];

    logic [DW-1:0] shadow_slots [DEPTH];
    int shadow_head = 1 % DEPTH;
    int shadow_fill = 0;

    int burst_left  = 0;
    int gap_left    = 0;
    int stall_style = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int fail_count  = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int times_full  = 0;
    int status_seen [4];
    rbd_pkg::res_word_t want;

    ring_buffer_deque_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic rbd_pkg::cmd_word_t make_cmd(rbd_pkg::op_t op, logic [DW-1:0] v,
                                                    logic [PSW-1:0] p);
        rbd_pkg::cmd_word_t w;
        w.operation = op;
        w.value     = v;
        w.position  = p;
        return w;
    endfunction

    function automatic void add_cmd(rbd_pkg::cmd_word_t w);
        pending_cmds = {pending_cmds, w};
    endfunction

    function automatic logic [DW-1:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return DW'($urandom);
    endfunction

    // mode 0 leans to pushes, 1 to pops, 2 to reads, others uniform
    function automatic rbd_pkg::op_t pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return rbd_pkg::OP_CLEAR;
        case (mode)
            0: if (r < 72) return r[0] ? rbd_pkg::OP_PUSH_BACK : rbd_pkg::OP_PUSH_FRONT;
            1: if (r < 60) return r[0] ? rbd_pkg::OP_POP_BACK : rbd_pkg::OP_POP_FRONT;
            2:
                if (r < 60)
                    return rbd_pkg::op_t'($urandom_range(int'(rbd_pkg::OP_READ_FRONT),
                                                         int'(rbd_pkg::OP_READ_AT)));
            default: ;
        endcase
        return rbd_pkg::op_t'($urandom_range(int'(rbd_pkg::OP_PUSH_FRONT),
                                             int'(rbd_pkg::OP_READ_AT)));
    endfunction

    function automatic rbd_pkg::res_word_t apply_to_shadow(rbd_pkg::cmd_word_t w);
        rbd_pkg::res_word_t r;
        r.read_data = '0;
        r.status    = rbd_pkg::ST_OK;
        case (w.operation)
            rbd_pkg::OP_PUSH_FRONT:
                if (shadow_fill >= DEPTH)
                    r.status = rbd_pkg::ST_FULL;
                else
                begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_head] = w.value;
                    shadow_fill++;
                end
            rbd_pkg::OP_PUSH_BACK:
                if (shadow_fill >= DEPTH)
                    r.status = rbd_pkg::ST_FULL;
                else
                begin
                    shadow_slots[(shadow_head + shadow_fill) % DEPTH] = w.value;
                    shadow_fill++;
                end
            rbd_pkg::OP_POP_FRONT:
                if (shadow_fill == 0)
                    r.status = rbd_pkg::ST_EMPTY;
                else
                begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end
            rbd_pkg::OP_POP_BACK:
                if (shadow_fill == 0)
                    r.status = rbd_pkg::ST_EMPTY;
                else
                    shadow_fill--;
            rbd_pkg::OP_READ_FRONT:
                if (shadow_fill == 0)
                    r.status = rbd_pkg::ST_EMPTY;
                else
                    r.read_data = shadow_slots[shadow_head];
            rbd_pkg::OP_READ_BACK:
                if (shadow_fill == 0)
                    r.status = rbd_pkg::ST_EMPTY;
                else
                    r.read_data = shadow_slots[(shadow_head + shadow_fill - 1) % DEPTH];
            rbd_pkg::OP_READ_AT:
                if (int'(w.position) >= shadow_fill)
                    r.status = rbd_pkg::ST_RANGE;
                else
                    r.read_data = shadow_slots[(shadow_head + int'(w.position)) % DEPTH];
            default:
            begin
                shadow_fill = 0;
                shadow_head = 1 % DEPTH;
            end
        endcase
        r.count = CW'(shadow_fill);
        return r;
    endfunction

    // driver: bursts of words separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_results = {expected_results, apply_to_shadow(cmd)};
                words_sent++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd       <= pending_cmds[0];
                    pending_cmds.delete(0);
                    cmd_valid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                : $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = $urandom_range(1, 8);
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // result side: stall style changes from phase to phase
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 120);
            end
            stall_left--;
            case (stall_style)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= ($urandom_range(0, 1) == 0);
                default: res_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            words_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: %p", res);
                fail_count++;
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (res.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, res.read_data);
                    fail_count++;
                end
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    fail_count++;
                end
                if (res.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, res.count);
                    fail_count++;
                end
                status_seen[int'(want.status)]++;
                if (int'(want.count) == DEPTH)
                    times_full++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int left;
        int seg_len;
        int mode;

        // empty deque: every read and pop must fail; then two pushes and offset reads
        add_cmd(make_cmd(rbd_pkg::OP_POP_FRONT, '1, '1));
        add_cmd(make_cmd(rbd_pkg::OP_POP_BACK, '1, '1));
        add_cmd(make_cmd(rbd_pkg::OP_READ_FRONT, '0, '0));
        add_cmd(make_cmd(rbd_pkg::OP_READ_BACK, '0, '0));
        add_cmd(make_cmd(rbd_pkg::OP_READ_AT, '0, '0));
        add_cmd(make_cmd(rbd_pkg::OP_PUSH_FRONT, '0, '0));
        add_cmd(make_cmd(rbd_pkg::OP_PUSH_BACK, '1, '1));
        add_cmd(make_cmd(rbd_pkg::OP_READ_AT, '0, 4'd1));
        add_cmd(make_cmd(rbd_pkg::OP_READ_AT, '0, 4'd2));
        // fill to full depth
        for (int i = 0; i < DEPTH - 2; i++)
            add_cmd(make_cmd(i[0] ? rbd_pkg::OP_PUSH_BACK : rbd_pkg::OP_PUSH_FRONT,
                             random_value(), 4'($urandom_range(0, 15))));
        add_cmd(make_cmd(rbd_pkg::OP_PUSH_FRONT, '1, '0));
        add_cmd(make_cmd(rbd_pkg::OP_PUSH_BACK, '0, '1));
        add_cmd(make_cmd(rbd_pkg::OP_READ_AT, '0, '1));
        add_cmd(make_cmd(rbd_pkg::OP_CLEAR, '1, '1));
        add_cmd(make_cmd(rbd_pkg::OP_READ_AT, '1, '0));

        left = RANDOM_WORDS;
        while (left > 0)
        begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 40);
            if (seg_len > left)
                seg_len = left;
            repeat (seg_len)
                add_cmd(make_cmd(pick_op(mode), random_value(),
                                 4'($urandom_range(0, 15))));
            left -= seg_len;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d commands, %0d results: ok %0d, empty %0d, full %0d, range %0d",
                 words_sent, words_seen, status_seen[int'(rbd_pkg::ST_OK)],
                 status_seen[int'(rbd_pkg::ST_EMPTY)], status_seen[int'(rbd_pkg::ST_FULL)],
                 status_seen[int'(rbd_pkg::ST_RANGE)]);
        $display("deque held full depth after %0d results, %0d mismatches",
                 times_full, fail_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
